>>> src/binary_min_heap_queue_core_macros.svh
// assertion macros for the min-heap queue core
// used by binary_min_heap_queue_core; expects clk_i and rst_ni in scope
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// property checked outside reset
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define BMHQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/bmhq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the min-heap queue core
// no dependencies

package bmhq_pkg;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bmhq_status_e;

  // per-transaction command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic ext;
  } bmhq_ctrl_t;

endpackage

>>> src/bmhq_cell.sv
`timescale 1ns / 1ps
// one cell of the sorted queue chain: holds one entry, shifts right on insert
// and left on extract; depends on bmhq_pkg

module bmhq_cell import bmhq_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  bmhq_ctrl_t            ctrl_i,
  input  logic                  occ_i,
  input  logic [VALUE_BITS-1:0] ins_val_i,
  input  logic                  left_mv_i,
  input  logic [VALUE_BITS-1:0] left_val_i,
  input  logic [VALUE_BITS-1:0] right_val_i,
  output logic                  mv_o,
  output logic [VALUE_BITS-1:0] val_o
);

  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] val_d;

  // this cell and every one to its right makes room for the new value
  assign mv_o = ctrl_i.ins && (!occ_i || (val_q > ins_val_i));

  always_comb begin
    val_d = val_q;
    if (mv_o) begin
      val_d = left_mv_i ? left_val_i : ins_val_i;
    end else if (ctrl_i.ext) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

>>> src/binary_min_heap_queue_core.sv
`timescale 1ns / 1ps
// min-priority queue core: chain of bmhq_cell entries kept in sorted order
// depends on bmhq_pkg, bmhq_cell and binary_min_heap_queue_core_macros.svh
//
//  channel  dir  tdata                               tuser
//  s_axis   in   value[15:0]                         op
//  m_axis   out  min_value[15:0], occupancy[22:16]   value_valid[0], status[2:1]
//
// one transaction per cycle while s_axis_tready is high; its result is registered and shows the next cycle
// each insert or extract finishes in a single shift of the cell chain
// reset clears the entry count and the output valid flag; cell contents and output data stay
// s_axis_tready drops only while a result waits and m_axis_tready is low

module binary_min_heap_queue_core import bmhq_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // value[15:0]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // min_value[15:0], occupancy[22:16], pad
  output logic [2:0]  m_axis_tuser    // value_valid[0], status[2:1]
);

`include "binary_min_heap_queue_core_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]         count_q, count_d;
  logic                  out_vld_q;
  logic [15:0]           min_q;
  logic                  vv_q;
  bmhq_status_e          status_q, status_d;
  logic [6:0]            occ_q;

  logic                  accept;
  logic                  full, empty;
  bmhq_ctrl_t            ctrl;
  logic [VALUE_BITS-1:0] ins_val;
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic                  cell_mv  [CAPACITY];

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CW'(CAPACITY));
  assign empty         = (count_q == '0);
  assign ins_val       = VALUE_BITS'(s_axis_tdata);

  assign ctrl.ins = accept && (s_axis_tuser == OP_INSERT) && !full;
  assign ctrl.ext = accept && (s_axis_tuser == OP_EXTRACT) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  left_mv;
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_mv  = 1'b0;
      assign left_val = ins_val;
    end else begin : g_body
      assign left_mv  = cell_mv[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_link
      assign right_val = cell_val[i+1];
    end

    bmhq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (CW'(i) < count_q),
      .ins_val_i  (ins_val),
      .left_mv_i  (left_mv),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .mv_o       (cell_mv[i]),
      .val_o      (cell_val[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.ext) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    status_d = ST_OK;
    if (s_axis_tuser == OP_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end
    end else if (empty) begin
      status_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q    <= ctrl.ext ? 16'(cell_val[0]) : 16'd0;
      vv_q     <= ctrl.ext;
      status_q <= status_d;
      occ_q    <= 7'(count_d);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, occ_q, min_q};
  assign m_axis_tuser  = {status_q, vv_q};

  `BMHQ_ASSERT(a_count_range, count_q <= CW'(CAPACITY), "entry count above capacity")
  `BMHQ_ASSERT(a_ext_count, ctrl.ext |=> (count_q == $past(count_q) - CW'(1)), "extract count slip")
  `BMHQ_ASSERT(a_head_min, (count_q >= CW'(2)) |-> (cell_val[0] <= cell_val[1]), "chain not sorted")

endmodule
